FILE: rtl/core/wrc_pkg.sv
package wrc_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int WDAY_W  = 3;
   localparam int CNT_W   = 14;
   localparam int CENT_W  = 8;   // year / 100, covers any 14-bit year
   localparam int YOC_W   = 7;   // year % 100
   localparam int SUM_W   = 10;  // Zeller sum before mod 7, at most 712

   localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
   localparam logic [YOC_W-1:0]   YOC_LAST   = 7'd99;
   localparam logic [WDAY_W-1:0]  DAYS_WEEK  = 3'd7;

   // floor(y / 100) = (y * 5243) >> 19 for every 14-bit y
   localparam logic [12:0] DIV100_RECIP = 13'd5243;
   localparam int          DIV100_SHIFT = 19;
   localparam logic [6:0]  HUNDRED      = 7'd100;

   // floor(s / 7) = (s * 37450) >> 18 for s below 1024
   localparam logic [15:0] DIV7_RECIP = 16'd37450;
   localparam int          DIV7_SHIFT = 18;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPLIT_START,
      ST_REM_START,
      ST_CHECK,
      ST_SPLIT_ZEL,
      ST_REM_ZEL,
      ST_SUM,
      ST_MOD,
      ST_SCAN,
      ST_DONE
   } wrc_state_type;

   typedef struct packed {
      logic load;     // capture request
      logic split;    // century = year / 100
      logic rem;      // year of century = year - 100 * century
      logic check;    // validate, set up Zeller year
      logic sum;      // Zeller sum
      logic modr;     // sum mod 7
      logic scan;     // advance one year
   } wrc_ctl_type;

   typedef struct packed {
      logic ok;        // request valid, meaningful in ST_CHECK
      logic scan_end;  // last year reached
   } wrc_stat_type;

   function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         MONTH_FEB:                                   len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

   // floor(13 * (m' + 1) / 5), with Jan and Feb as months 13 and 14
   function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
      logic [5:0] t;
      case (m)
         4'd1:    t = 6'd36;
         4'd2:    t = 6'd39;
         4'd3:    t = 6'd10;
         4'd4:    t = 6'd13;
         4'd5:    t = 6'd15;
         4'd6:    t = 6'd18;
         4'd7:    t = 6'd20;
         4'd8:    t = 6'd23;
         4'd9:    t = 6'd26;
         4'd10:   t = 6'd28;
         4'd11:   t = 6'd31;
         4'd12:   t = 6'd33;
         default: t = 6'd0;
      endcase
      return t;
   endfunction

   // Gregorian leap rule from century and year of century
   function automatic logic is_leap(input logic [CENT_W-1:0] cent,
                                    input logic [YOC_W-1:0] yoc);
      return (yoc[1:0] == 2'd0) && ((yoc != '0) || (cent[1:0] == 2'd0));
   endfunction

endpackage

FILE: rtl/core/wrc_if.sv
interface wrc_req_if;
   import wrc_pkg::*;

   logic                valid;
   logic                ready;
   logic [YEAR_W-1:0]   start_year;
   logic [MONTH_W-1:0]  month;
   logic [DAY_W-1:0]    day;
   logic [YEAR_W-1:0]   stop_year;

   modport source (output valid, start_year, month, day, stop_year, input ready);
   modport sink   (input valid, start_year, month, day, stop_year, output ready);
endinterface

interface wrc_rsp_if;
   import wrc_pkg::*;

   logic                valid;
   logic                ready;
   logic                date_valid;
   logic [WDAY_W-1:0]   weekday;
   logic [CNT_W-1:0]    same_weekday_count;

   modport source (output valid, date_valid, weekday, same_weekday_count, input ready);
   modport sink   (input valid, date_valid, weekday, same_weekday_count, output ready);
endinterface

FILE: rtl/core/weekday_and_recurrence_counter_core.sv
// Weekday and recurrence counter.
// req_chan carries one transaction: start_year, month, day, stop_year. The
// core checks the date (Gregorian leap rule) and the stop year, computes the
// weekday of the date by Zeller's congruence (0 Saturday .. 6 Friday), then
// steps year by year up to stop_year counting years whose same month and day
// fall on that weekday. rsp_chan returns date_valid, weekday and the count;
// invalid requests return all zeros.
// One request at a time: req_chan.ready is high only while idle.
// An invalid request passes the split, remainder and check states before
// rsp_chan.valid; a valid one then runs the Zeller split, remainder, sum and
// mod states and the per-year scan, which steps the single weekday
// accumulator once per year.
// The result holds on rsp_chan until taken; the core stays busy meanwhile.
// Synchronous reset returns the sequencer to idle; no request is in flight
// after reset.
module weekday_and_recurrence_counter_core (
   input  logic      clock,
   input  logic      reset,
   wrc_req_if.sink   req_chan,
   wrc_rsp_if.source rsp_chan
);
   import wrc_pkg::*;

   wrc_ctl_type  ctl;
   wrc_stat_type stat;

   wrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .ctl       (ctl)
   );

   wrc_datapath u_datapath (
      .clock              (clock),
      .ctl                (ctl),
      .start_year         (req_chan.start_year),
      .month              (req_chan.month),
      .day                (req_chan.day),
      .stop_year          (req_chan.stop_year),
      .stat               (stat),
      .date_valid         (rsp_chan.date_valid),
      .weekday            (rsp_chan.weekday),
      .same_weekday_count (rsp_chan.same_weekday_count)
   );

endmodule

FILE: rtl/core/wrc_ctrl.sv
module wrc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_ready,
   input  wrc_pkg::wrc_stat_type stat,
   output logic                  req_ready,
   output logic                  rsp_valid,
   output wrc_pkg::wrc_ctl_type  ctl
);
   import wrc_pkg::*;

   wrc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:        if (req_valid) state_in = ST_SPLIT_START;
         ST_SPLIT_START: state_in = ST_REM_START;
         ST_REM_START:   state_in = ST_CHECK;
         ST_CHECK:       state_in = stat.ok ? ST_SPLIT_ZEL : ST_DONE;
         ST_SPLIT_ZEL:   state_in = ST_REM_ZEL;
         ST_REM_ZEL:     state_in = ST_SUM;
         ST_SUM:         state_in = ST_MOD;
         ST_MOD:         state_in = ST_SCAN;
         ST_SCAN:        if (stat.scan_end) state_in = ST_DONE;
         ST_DONE:        if (rsp_ready) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         ST_SPLIT_START, ST_SPLIT_ZEL: ctl.split = 1'b1;
         ST_REM_START, ST_REM_ZEL:     ctl.rem   = 1'b1;
         ST_CHECK:                     ctl.check = 1'b1;
         ST_SUM:                       ctl.sum   = 1'b1;
         ST_MOD:                       ctl.modr  = 1'b1;
         ST_SCAN:                      ctl.scan  = !stat.scan_end;
         ST_DONE:                      rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/core/wrc_datapath.sv
module wrc_datapath (
   input  logic                           clock,
   input  wrc_pkg::wrc_ctl_type           ctl,
   input  logic [wrc_pkg::YEAR_W-1:0]     start_year,
   input  logic [wrc_pkg::MONTH_W-1:0]    month,
   input  logic [wrc_pkg::DAY_W-1:0]      day,
   input  logic [wrc_pkg::YEAR_W-1:0]     stop_year,
   output wrc_pkg::wrc_stat_type          stat,
   output logic                           date_valid,
   output logic [wrc_pkg::WDAY_W-1:0]     weekday,
   output logic [wrc_pkg::CNT_W-1:0]      same_weekday_count
);
   import wrc_pkg::*;

   logic [YEAR_W-1:0]  sy_ff, end_ff, yr_ff, yr_in, scan_ff;
   logic [MONTH_W-1:0] mon_ff;
   logic [DAY_W-1:0]   day_ff;
   logic [CENT_W-1:0]  cent_ff, cent_in;
   logic [YOC_W-1:0]   yoc_ff, yoc_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [WDAY_W-1:0]  wd_ff, wd_in, cur_ff, cur_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               valid_ff, valid_in;

   logic [26:0]        div100_prod;
   logic [14:0]        hund;
   logic [14:0]        rem_diff;
   logic               leap_start, ok;
   logic [25:0]        div7_prod;
   logic [7:0]         q7;
   logic [SUM_W-1:0]   r7;
   logic [YOC_W-1:0]   nyoc;
   logic [CENT_W-1:0]  ncent;
   logic [3:0]         step_sum;
   logic [WDAY_W-1:0]  ncur;

   // shared constant-reciprocal divide by 100 and remainder
   assign div100_prod = yr_ff * DIV100_RECIP;
   assign cent_in     = div100_prod[DIV100_SHIFT +: CENT_W];
   assign hund        = cent_ff * HUNDRED;
   assign rem_diff    = {1'b0, yr_ff} - hund;
   assign yoc_in      = rem_diff[YOC_W-1:0];

   // year % 4 equals year-of-century % 4
   assign leap_start = is_leap(cent_ff, yoc_ff);
   assign ok = (sy_ff != '0) && (sy_ff <= YEAR_MAX) &&
               (end_ff != '0) && (end_ff <= YEAR_MAX) &&
               (mon_ff != '0) && (mon_ff <= MONTH_DEC) &&
               (day_ff != '0) && (day_ff <= month_len(leap_start, mon_ff));

   // Jan and Feb count as months of the previous year
   assign yr_in = sy_ff - {{(YEAR_W-1){1'b0}}, (mon_ff <= MONTH_FEB)};

   assign sum_in = SUM_W'(day_ff) + SUM_W'(month_term(mon_ff)) + SUM_W'(yoc_ff) +
                   SUM_W'(yoc_ff >> 2) + SUM_W'(cent_ff >> 2) +
                   SUM_W'({cent_ff, 2'b00}) + SUM_W'(cent_ff);

   assign div7_prod = sum_ff * DIV7_RECIP;
   assign q7        = div7_prod[DIV7_SHIFT +: 8];
   assign r7        = sum_ff - SUM_W'(q7) * SUM_W'(DAYS_WEEK);
   assign wd_in     = r7[WDAY_W-1:0];

   // next Zeller year: weekday moves by 1, or 2 when that year is leap
   assign nyoc     = (yoc_ff == YOC_LAST) ? '0 : yoc_ff + 1'b1;
   assign ncent    = (yoc_ff == YOC_LAST) ? cent_ff + 1'b1 : cent_ff;
   assign step_sum = {1'b0, cur_ff} + 4'd1 + {3'b000, is_leap(ncent, nyoc)};
   assign ncur     = (step_sum >= {1'b0, DAYS_WEEK}) ?
                     WDAY_W'(step_sum - {1'b0, DAYS_WEEK}) : step_sum[WDAY_W-1:0];

   always_comb begin
      cur_in   = cur_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      if (ctl.load) begin
         cnt_in   = '0;
         valid_in = 1'b0;
      end else if (ctl.check) begin
         valid_in = ok;
      end else if (ctl.modr) begin
         cur_in = wd_in;
      end else if (ctl.scan) begin
         cur_in = ncur;
         if (ncur == wd_ff) cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      cnt_ff   <= cnt_in;
      valid_ff <= valid_in;
      if (ctl.load) begin
         sy_ff   <= start_year;
         mon_ff  <= month;
         day_ff  <= day;
         end_ff  <= stop_year;
         yr_ff   <= start_year;
         scan_ff <= start_year;
         wd_ff   <= '0;
      end
      if (ctl.check) yr_ff <= yr_in;
      if (ctl.split) cent_ff <= cent_in;
      if (ctl.rem) yoc_ff <= yoc_in;
      if (ctl.sum) sum_ff <= sum_in;
      if (ctl.modr) wd_ff <= wd_in;
      if (ctl.scan) begin
         yoc_ff  <= nyoc;
         cent_ff <= ncent;
         scan_ff <= scan_ff + 1'b1;
      end
   end

   assign stat.ok       = ok;
   assign stat.scan_end = (scan_ff >= end_ff);

   assign date_valid         = valid_ff;
   assign weekday            = wd_ff;
   assign same_weekday_count = cnt_ff;

endmodule

FILE: tb/weekday_and_recurrence_counter_core_tb.sv
module weekday_and_recurrence_counter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wrc_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 4;
   localparam int RANDOM_QUERIES = 100;
   localparam int LONG_HOLD      = 600;
   localparam int TAIL_CYCLES    = 40;
   localparam int TIMEOUT_CYCLES = 5_000_000;
   localparam int YEAR_SPAN      = 1 << YEAR_W;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [YEAR_W-1:0]  start_year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [YEAR_W-1:0]  stop_year;
   } date_query_type;

   typedef struct packed {
      logic              date_valid;
      logic [WDAY_W-1:0] weekday;
      logic [CNT_W-1:0]  same_weekday_count;
   } recurrence_type;

   // Expected weekday and recurrence count per accepted query, checked in order.
   class recurrence_ledger;
      recurrence_type expected_q[$];
      int             mismatches;
      int             unexpected;

      static function bit leap_year(int unsigned y);
         if (y % 400 == 0) return 1'b1;
         if (y % 100 == 0) return 1'b0;
         return (y % 4) == 0;
      endfunction

      static function int unsigned month_days(int unsigned y, int unsigned m);
         case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            MONTH_FEB:             return leap_year(y) ? 29 : 28;
            default:               return 0;
         endcase
      endfunction

      // Jan and Feb count as months 13 and 14 of the previous year
      static function int unsigned zeller_day(int unsigned y, int unsigned m,
                                              int unsigned d);
         int unsigned cent, yoc;
         if (m <= MONTH_FEB) begin
            y -= 1;
            m += 12;
         end
         cent = y / 100;
         yoc  = y % 100;
         return (d + (13 * (m + 1)) / 5 + yoc + yoc / 4 + cent / 4 + 5 * cent) % 7;
      endfunction

      function void note_request(date_query_type q);
         recurrence_type r;
         int unsigned sy, m, d, ey, wd, cnt;
         bit ok;
         sy = q.start_year;
         m  = q.month;
         d  = q.day;
         ey = q.stop_year;
         r  = '0;
         ok = sy >= 1 && sy <= YEAR_MAX && ey >= 1 && ey <= YEAR_MAX &&
              m >= 1 && m <= MONTH_DEC && d >= 1 && d <= month_days(sy, m);
         if (ok) begin
            wd  = zeller_day(sy, m, d);
            cnt = 0;
            for (int unsigned y = sy + 1; y <= ey; y++)
               if (zeller_day(y, m, d) == wd) cnt++;
            r.date_valid         = 1'b1;
            r.weekday            = wd[WDAY_W-1:0];
            r.same_weekday_count = cnt[CNT_W-1:0];
         end
         expected_q.push_back(r);
      endfunction

      function void check_answer(recurrence_type got);
         recurrence_type exp;
         if (expected_q.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= REPORT_LIMIT)
               $display("unexpected result: valid=%0d weekday=%0d count=%0d",
                        got.date_valid, got.weekday, got.same_weekday_count);
            return;
         end
         exp = expected_q.pop_front();
         if (got.date_valid !== exp.date_valid || got.weekday !== exp.weekday ||
             got.same_weekday_count !== exp.same_weekday_count) begin
            mismatches++;
            if (mismatches + unexpected <= REPORT_LIMIT)
               $display("mismatch: exp valid=%0d wd=%0d cnt=%0d, got valid=%0d wd=%0d cnt=%0d",
                        exp.date_valid, exp.weekday, exp.same_weekday_count,
                        got.date_valid, got.weekday, got.same_weekday_count);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int failures();
         return mismatches + unexpected + expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   wrc_req_if req ();
   wrc_rsp_if rsp ();

   recurrence_ledger ledger;
   bit               long_hold_pending = 1'b0;
   int               burst_left = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   weekday_and_recurrence_counter_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         ledger.note_request('{req.start_year, req.month, req.day, req.stop_year});
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         ledger.check_answer('{rsp.date_valid, rsp.weekday, rsp.same_weekday_count});
   end

   // Receiver: segments of always-ready, half and quarter acceptance, plus
   // one long hold-off on request.
   initial begin : receiver
      int seg_left;
      int seg_mode;
      seg_left = 0;
      seg_mode = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (seg_left == 0) begin
               seg_mode = $urandom_range(0, 2);
               seg_left = $urandom_range(1, 40);
            end
            seg_left--;
            case (seg_mode)
               0:       rsp.ready <= 1'b1;
               1:       rsp.ready <= $urandom_range(0, 1);
               default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic date_query_type make_query(int unsigned sy, int unsigned m,
                                                 int unsigned d, int unsigned ey);
      make_query = '{sy[YEAR_W-1:0], m[MONTH_W-1:0], d[DAY_W-1:0], ey[YEAR_W-1:0]};
   endfunction

   function automatic date_query_type random_query();
      int unsigned sy, m, d, ey, len, pick, span;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         return make_query($urandom_range(0, YEAR_SPAN - 1), $urandom_range(0, 15),
                           $urandom_range(0, 31), $urandom_range(0, YEAR_SPAN - 1));
      sy = $urandom_range(1, YEAR_MAX);
      m  = $urandom_range(1, MONTH_DEC);
      if (pick < 25) begin
         // February start in a leap year, later years mostly not leap
         sy = 4 * $urandom_range(1, 2499);
         if (!recurrence_ledger::leap_year(sy)) sy += 4;
         m = MONTH_FEB;
      end
      len = recurrence_ledger::month_days(sy, m);
      d   = $urandom_range(1, len);
      span = $urandom_range(0, 99);
      if (span < 4)
         ey = $urandom_range(sy, YEAR_MAX);
      else if (span < 14)
         ey = $urandom_range(1, sy);
      else if (span < 18)
         ey = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(YEAR_MAX + 1, YEAR_SPAN - 1);
      else begin
         ey = sy + $urandom_range(0, 120);
         if (ey > YEAR_MAX) ey = YEAR_MAX;
      end
      if (span >= 18 && span < 22 && len < 31)
         d = $urandom_range(len + 1, 31);
      return make_query(sy, m, d, ey);
   endfunction

   // Called just after the clock rises; returns in the time step in which the core accepts the query.
   task automatic offer_query(date_query_type q);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req.start_year <= q.start_year;
      req.month      <= q.month;
      req.day        <= q.day;
      req.stop_year  <= q.stop_year;
      req.valid      <= 1'b1;
      do @(posedge clock); while (!req.ready);
   endtask

   // the ledger notes the last accepted transaction within the accepting step
   task automatic wait_until_drained();
      do @(posedge clock); while (ledger.pending() != 0);
   endtask

   initial begin : stimulus
      date_query_type directed[$];
      ledger = new();
      reset          <= 1'b1;
      req.valid      <= 1'b0;
      req.start_year <= '0;
      req.month      <= '0;
      req.day        <= '0;
      req.stop_year  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(make_query(1, 1, 1, YEAR_MAX));
      directed.push_back(make_query(1, 1, 1, 1));
      directed.push_back(make_query(YEAR_MAX, MONTH_DEC, 31, YEAR_MAX));
      directed.push_back(make_query(2000, MONTH_FEB, 29, 2100));
      directed.push_back(make_query(1900, MONTH_FEB, 29, 1950));
      directed.push_back(make_query(1600, MONTH_FEB, 29, 1700));
      directed.push_back(make_query(2024, MONTH_FEB, 29, 2060));
      directed.push_back(make_query(4, MONTH_FEB, 29, YEAR_MAX));
      directed.push_back(make_query(2023, MONTH_FEB, 29, 2030));
      directed.push_back(make_query(2023, MONTH_FEB, 28, 2050));
      directed.push_back(make_query(5000, 6, 15, 100));
      directed.push_back(make_query(2020, 0, 10, 2030));
      directed.push_back(make_query(2020, 5, 0, 2030));
      directed.push_back(make_query(2020, 13, 10, 2030));
      directed.push_back(make_query(2020, 15, 31, 2030));
      directed.push_back(make_query(2021, 4, 31, 2030));
      directed.push_back(make_query(2021, 1, 31, 2040));
      directed.push_back(make_query(0, 3, 3, 2030));
      directed.push_back(make_query(YEAR_MAX + 1, 3, 3, YEAR_MAX));
      directed.push_back(make_query(YEAR_SPAN - 1, 3, 3, YEAR_MAX));
      directed.push_back(make_query(1999, 7, 4, 0));
      directed.push_back(make_query(1999, 7, 4, YEAR_MAX + 1));
      directed.push_back(make_query(1999, 7, 4, YEAR_SPAN - 1));
      foreach (directed[i]) offer_query(directed[i]);

      // sender pause until every result is back
      req.valid <= 1'b0;
      burst_left = 0;
      wait_until_drained();
      @(posedge clock);

      // receiver stalls long while queries keep coming
      long_hold_pending = 1'b1;
      for (int i = 0; i < RANDOM_QUERIES; i++) offer_query(random_query());
      req.valid <= 1'b0;

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (ledger.failures() == 0)
         $display("weekday_and_recurrence_counter_core regression: pass");
      else
         $display("weekday_and_recurrence_counter_core regression: fail");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("weekday_and_recurrence_counter_core regression: fail");
      $finish;
   end

endmodule
